@@ sv/fractional_divider_register_gen_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the divider register generator checker
// Concurrent assertion wrappers sharing one clock and reset convention.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DIVIDER_REGISTER_GEN_MACROS_SVH
`define FRACTIONAL_DIVIDER_REGISTER_GEN_MACROS_SVH

// next-cycle implication, ignored while reset is high
`define FDRG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fdrg checker: property failed");

// next-cycle implication that also holds across reset
`define FDRG_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("fdrg checker: property failed");

`endif

@@ sv/fdrg_pkg.sv @@
// ----------------------------------------------------------------------------
// fdrg_pkg
// Types and constants shared by the divider register generator modules.
// ----------------------------------------------------------------------------
package fdrg_pkg;

   localparam int unsigned VCO_W    = 30;
   localparam int unsigned OFS_W    = 26;
   localparam int unsigned TGT_W    = 28;
   localparam int unsigned SUM_W    = 29;
   localparam int unsigned FRAC_W   = 20;
   localparam int unsigned P1_W     = 18;
   localparam int unsigned P2_W     = 20;

   // one sum stage, one stage per integer bit, one scaling stage, one per fraction bit
   localparam int unsigned DIV1_FIRST = 1;
   localparam int unsigned SCALE_STG  = DIV1_FIRST + VCO_W;
   localparam int unsigned DIV2_FIRST = SCALE_STG + 1;
   localparam int unsigned NUM_STG    = DIV2_FIRST + FRAC_W;

   localparam logic [FRAC_W:0]    DENOM     = 21'h0FFFFF;
   localparam logic [VCO_W-1:0]   A_MIN     = 30'd4;
   localparam logic [VCO_W-1:0]   A_MAX     = 30'd2051;
   localparam logic [P1_W-1:0]    P1_OFFSET = 18'd512;
   localparam logic [7:0]         BYTE_ONES = 8'hFF;
   localparam logic [3:0]         P2_HI_PAT = 4'hF;

   localparam logic [VCO_W-1:0]   VCO_RESET = 30'd900000000;
   localparam logic [OFS_W-1:0]   OFS_RESET = 26'd9000000;

   localparam logic CSR_VCO    = 1'b0;
   localparam logic CSR_OFFSET = 1'b1;

   localparam logic [2:0] BYTE_DEN_HI = 3'd0;
   localparam logic [2:0] BYTE_DEN_LO = 3'd1;
   localparam logic [2:0] BYTE_P1_HI  = 3'd2;
   localparam logic [2:0] BYTE_P1_MID = 3'd3;
   localparam logic [2:0] BYTE_P1_LO  = 3'd4;
   localparam logic [2:0] BYTE_P2_HI  = 3'd5;
   localparam logic [2:0] BYTE_P2_MID = 3'd6;
   localparam logic [2:0] BYTE_P2_LO  = 3'd7;

   typedef struct packed {
      logic [7:0]        base;
      logic [SUM_W-1:0]  sum;
      logic              zero;
      logic [VCO_W-1:0]  rem;
      logic [VCO_W-1:0]  dvd;
      logic [VCO_W-1:0]  qa;
      logic [FRAC_W-1:0] qb;
   } stage_type;

   typedef struct packed {
      logic [7:0]      base;
      logic [P1_W-1:0] p1;
      logic [P2_W-1:0] p2;
      logic            err;
   } res_type;

endpackage

@@ sv/fractional_divider_register_gen.sv @@
// ----------------------------------------------------------------------------
// fractional_divider_register_gen
// Turns a wanted frequency into eight fractional-N divider register writes.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: one transaction per request, tdata = target_frequency [27:0],
//    synth_base [35:28], zero fill to 40 bits.
//  rsp_ channel: eight transactions per request in address order, tdata =
//    reg_address [7:0], reg_byte [15:8]; tlast marks the eighth write and
//    tuser carries range_error on all eight.
//  csr_ port: index 0 is the VCO frequency, index 1 the offset frequency;
//    write only while no request is in flight.
//  Path from request to first write: one sum stage, 30 stages
//  of integer division, one scaling stage, 20 stages of fraction division,
//  one encode stage and the output hold register.
//  Throughput is set by the eight writes that the
//  output serialiser drives per request; the division pipeline takes a new
//  request every cycle until it fills.
//  A stalled rsp_ channel holds the current write and backs the pipeline up
//  without losing or repeating anything. Reset empties the pipeline and
//  restores 900000000 Hz and 9000000 Hz in the registers.
// ----------------------------------------------------------------------------
module fractional_divider_register_gen (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [39:0]                req_tdata,   // target_frequency, synth_base
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [15:0]                rsp_tdata,   // reg_address, reg_byte
   output logic                       rsp_tlast,
   output logic                       rsp_tuser,   // range_error
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [fdrg_pkg::VCO_W-1:0] csr_wdata
);
   import fdrg_pkg::*;

   logic [VCO_W-1:0] vco_ff;
   logic [OFS_W-1:0] ofs_ff;
   logic             res_valid;
   logic             res_ready;
   res_type          res;
   logic [7:0]       out_address;
   logic [7:0]       out_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         vco_ff <= VCO_RESET;
         ofs_ff <= OFS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VCO:    vco_ff <= csr_wdata;
            CSR_OFFSET: ofs_ff <= csr_wdata[OFS_W-1:0];
            default:    vco_ff <= vco_ff;
         endcase
      end
   end

   fdrg_core u_core (
      .clock            (clock),
      .reset            (reset),
      .vco_frequency    (vco_ff),
      .offset_frequency (ofs_ff),
      .in_valid         (req_tvalid),
      .in_ready         (req_tready),
      .in_target        (req_tdata[27:0]),
      .in_base          (req_tdata[35:28]),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res)
   );

   fdrg_serializer u_ser (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_address (out_address),
      .out_byte    (out_byte),
      .out_last    (rsp_tlast),
      .out_error   (rsp_tuser)
   );

   assign rsp_tdata = {out_byte, out_address};

endmodule

@@ sv/fdrg_core.sv @@
// ----------------------------------------------------------------------------
// fdrg_core
// Pipelined long division of the VCO frequency by the offset sum and the
// encoding of the p1/p2 divider parameters, one bit of quotient per division stage.
// ----------------------------------------------------------------------------
module fdrg_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [fdrg_pkg::VCO_W-1:0]  vco_frequency,
   input  logic [fdrg_pkg::OFS_W-1:0]  offset_frequency,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [fdrg_pkg::TGT_W-1:0]  in_target,
   input  logic [7:0]                  in_base,
   output logic                        res_valid,
   input  logic                        res_ready,
   output fdrg_pkg::res_type           res
);
   import fdrg_pkg::*;

   stage_type            st_ff  [NUM_STG];
   stage_type            st_in  [NUM_STG];
   logic [NUM_STG-1:0]   valid_ff;
   logic [NUM_STG-1:0]   en;
   logic                 res_valid_ff;
   res_type              res_ff;
   res_type              res_in;
   logic                 res_en;

   function automatic stage_type div1_step(stage_type s);
      stage_type        o;
      logic [VCO_W-1:0] r2;
      logic [VCO_W:0]   diff;
      o    = s;
      r2   = {s.rem[VCO_W-2:0], s.dvd[VCO_W-1]};
      diff = {1'b0, r2} - {2'b00, s.sum};
      o.dvd = {s.dvd[VCO_W-2:0], 1'b0};
      if (!diff[VCO_W]) begin
         o.rem = diff[VCO_W-1:0];
         o.qa  = {s.qa[VCO_W-2:0], 1'b1};
      end else begin
         o.rem = r2;
         o.qa  = {s.qa[VCO_W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic stage_type div2_step(stage_type s);
      stage_type        o;
      logic [VCO_W-1:0] r2;
      logic [VCO_W:0]   diff;
      o    = s;
      r2   = {s.rem[VCO_W-2:0], s.dvd[VCO_W-1]};
      diff = {1'b0, r2} - {2'b00, s.sum};
      o.dvd = {s.dvd[VCO_W-2:0], 1'b0};
      if (!diff[VCO_W]) begin
         o.rem = diff[VCO_W-1:0];
         o.qb  = {s.qb[FRAC_W-2:0], 1'b1};
      end else begin
         o.rem = r2;
         o.qb  = {s.qb[FRAC_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // rem * (2^20 - 1); top bits start the fraction division, low bits feed in
   function automatic stage_type scale_step(stage_type s);
      stage_type                o;
      logic [SUM_W+FRAC_W-1:0]  num;
      o   = s;
      num = {s.rem[SUM_W-1:0], {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, s.rem[SUM_W-1:0]};
      o.rem = {1'b0, num[SUM_W+FRAC_W-1:FRAC_W]};
      o.dvd = {num[FRAC_W-1:0], {(VCO_W-FRAC_W){1'b0}}};
      o.qb  = '0;
      return o;
   endfunction

   always_comb begin
      logic [SUM_W-1:0] s0;
      s0 = {1'b0, in_target} + {3'b000, offset_frequency};
      st_in[0].base = in_base;
      st_in[0].sum  = s0;
      st_in[0].zero = (s0 == '0);
      st_in[0].rem  = '0;
      st_in[0].dvd  = vco_frequency;
      st_in[0].qa   = '0;
      st_in[0].qb   = '0;
   end

   for (genvar k = 1; k < NUM_STG; k++) begin : g_stage
      if (k < SCALE_STG) begin : g_div1
         assign st_in[k] = div1_step(st_ff[k-1]);
      end else if (k == SCALE_STG) begin : g_scale
         assign st_in[k] = scale_step(st_ff[k-1]);
      end else begin : g_div2
         assign st_in[k] = div2_step(st_ff[k-1]);
      end
   end

   // a stage moves on when empty or when the stage after it moves
   assign res_en = !res_valid_ff || res_ready;
   always_comb begin
      en[NUM_STG-1] = !valid_ff[NUM_STG-1] || res_en;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NUM_STG; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STG; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // encode: q = floor(128b / DENOM) via estimate from the top bits and one fix-up
   always_comb begin
      stage_type         s;
      logic [VCO_W-1:0]  a;
      logic [FRAC_W-1:0] b;
      logic [FRAC_W+6:0] x;
      logic [6:0]        q0;
      logic [7:0]        q;
      logic [FRAC_W:0]   r;
      s  = st_ff[NUM_STG-1];
      a  = s.zero ? '0 : s.qa;
      b  = s.zero ? '0 : s.qb;
      x  = {b, 7'b0};
      q0 = x[FRAC_W+6:FRAC_W];
      r  = {1'b0, x[FRAC_W-1:0]} + {14'b0, q0};
      q  = {1'b0, q0};
      if (r >= DENOM) begin
         r = r - DENOM;
         q = q + 8'd1;
      end
      res_in.base = s.base;
      res_in.p1   = {a[10:0], 7'b0} + {10'b0, q} - P1_OFFSET;
      res_in.p2   = r[P2_W-1:0];
      res_in.err  = s.zero || (a < A_MIN) || (a > A_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (res_en) begin
         res_valid_ff <= valid_ff[NUM_STG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (res_en) begin
         res_ff <= res_in;
      end
   end

   assign in_ready  = en[0];
   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule

@@ sv/fdrg_serializer.sv @@
// ----------------------------------------------------------------------------
// fdrg_serializer
// Holds one encoded result and plays it out as eight register writes.
// ----------------------------------------------------------------------------
module fdrg_serializer (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   output logic              res_ready,
   input  fdrg_pkg::res_type res,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_address,
   output logic [7:0]        out_byte,
   output logic              out_last,
   output logic              out_error
);
   import fdrg_pkg::*;

   logic       full_ff;
   logic       full_in;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;
   res_type    hold_ff;
   logic       done;

   assign done      = full_ff && out_ready && (cnt_ff == BYTE_P2_LO);
   assign res_ready = !full_ff || done;

   always_comb begin
      full_in = full_ff;
      cnt_in  = cnt_ff;
      if (full_ff && out_ready) begin
         cnt_in = cnt_ff + 3'd1;
      end
      if (res_ready) begin
         full_in = res_valid;
         cnt_in  = BYTE_DEN_HI;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         cnt_ff  <= BYTE_DEN_HI;
      end else begin
         full_ff <= full_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         hold_ff <= res;
      end
   end

   always_comb begin
      unique case (cnt_ff)
         BYTE_DEN_HI: out_byte = BYTE_ONES;
         BYTE_DEN_LO: out_byte = BYTE_ONES;
         BYTE_P1_HI:  out_byte = {6'b0, hold_ff.p1[17:16]};
         BYTE_P1_MID: out_byte = hold_ff.p1[15:8];
         BYTE_P1_LO:  out_byte = hold_ff.p1[7:0];
         BYTE_P2_HI:  out_byte = {P2_HI_PAT, hold_ff.p2[19:16]};
         BYTE_P2_MID: out_byte = hold_ff.p2[15:8];
         BYTE_P2_LO:  out_byte = hold_ff.p2[7:0];
         default:     out_byte = BYTE_ONES;
      endcase
   end

   assign out_valid   = full_ff;
   assign out_address = hold_ff.base + {5'b0, cnt_ff};
   assign out_last    = (cnt_ff == BYTE_P2_LO);
   assign out_error   = hold_ff.err;

endmodule

@@ sv/fdrg_checker.sv @@
// ----------------------------------------------------------------------------
// fdrg_checker
// Port-level checks on the register write stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "fractional_divider_register_gen_macros.svh"

module fdrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   `FDRG_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // within a run the writes follow one another at consecutive addresses
   `FDRG_ASSERT_NEXT(a_addr_step, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tdata[7:0] == 8'($past(rsp_tdata[7:0]) + 8'd1)))

   // the error flag is a property of the whole run
   `FDRG_ASSERT_NEXT(a_err_run, rsp_tvalid && rsp_tready && !rsp_tlast, $stable(rsp_tuser))

   `FDRG_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_tvalid)

endmodule

bind fractional_divider_register_gen fdrg_checker u_fdrg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

@@ verif/fractional_divider_register_gen_tb.sv @@
// ----------------------------------------------------------------------------
// fractional_divider_register_gen_tb
// Drives frequency requests through the divider register generator under
// random source gaps and sink stalls, predicts the eight register writes of
// each request and compares every write transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fractional_divider_register_gen_tb;
   import fdrg_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 80;

   // packed to match tdata: target in the low bits, base above it
   typedef struct packed {
      logic [7:0]  base;
      logic [27:0] target;
   } freq_req_t;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
      logic       range_err;
   } reg_write_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic csr_index = CSR_VCO;
   logic [VCO_W-1:0] csr_wdata = '0;

   freq_req_t  pending_reqs[$];
   reg_write_t expected_writes[$];
   logic [VCO_W-1:0] vco_hz;
   logic [OFS_W-1:0] offset_hz;
   int errors = 0;
   int writes_seen = 0;
   int reqs_sent = 0;
   int errs_seen = 0;
   int cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   bit hold_off = 1'b0;
   int stall_phase = 0;
   bit stall_mode = 1'b0;

   fractional_divider_register_gen DUT (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // expected write sequence for one request, using the current register values
   task automatic predict_writes(input freq_req_t r);
      logic [63:0] sum, a, b, rem, q, p1, p2;
      logic [7:0] bytes[8];
      reg_write_t w;
      bit err;
      sum = 64'(r.target) + 64'(offset_hz);
      a = 0;
      b = 0;
      if (sum != 0) begin
         a = 64'(vco_hz) / sum;
         rem = 64'(vco_hz) % sum;
         b = (rem * 64'd1048575) / sum;
      end
      err = (sum == 0) || (a < 4) || (a > 2051);
      q = (128 * b) / 64'd1048575;
      p1 = (128 * a + q - 512) & 64'h3FFFF;
      p2 = (128 * b - 64'd1048575 * q) & 64'hFFFFF;
      bytes[0] = 8'hFF;
      bytes[1] = 8'hFF;
      bytes[2] = {6'b0, p1[17:16]};
      bytes[3] = p1[15:8];
      bytes[4] = p1[7:0];
      bytes[5] = {4'hF, p2[19:16]};
      bytes[6] = p2[15:8];
      bytes[7] = p2[7:0];
      for (int k = 0; k < 8; k++) begin
         w.addr = r.base + 8'(k);
         w.data = bytes[k];
         w.last = (k == 7);
         w.range_err = err;
         expected_writes.push_back(w);
      end
   endtask

   // request driver: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_writes(freq_req_t'(req_tdata[35:0]));
            reqs_sent <= reqs_sent + 1;
            void'(pending_reqs.pop_front());
         end
         if (gap_left > 0 || hold_off || pending_reqs.size() == 0 ||
             (req_tvalid && req_tready && pending_reqs.size() == 0)) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            if (!(req_tvalid && !req_tready)) req_tvalid <= 1'b0;
         end else if (!(req_tvalid && !req_tready)) begin
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               req_tvalid <= 1'b0;
            end else begin
               burst_left <= burst_left - 1;
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0, pending_reqs[0]};
            end
         end
      end
   end

   // write monitor and sink stalls
   always @(posedge clock) begin
      reg_write_t got, exp_w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_mode <= $urandom_range(0, 2) != 0;
            stall_phase <= $urandom_range(4, 60);
         end else begin
            stall_phase <= stall_phase - 1;
         end
         rsp_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser};
            writes_seen <= writes_seen + 1;
            if (rsp_tuser) errs_seen <= errs_seen + 1;
            if (expected_writes.size() == 0) begin
               $error("unexpected write transaction addr %0h", got.addr);
               errors++;
            end else begin
               exp_w = expected_writes.pop_front();
               if (got.addr != exp_w.addr) begin
                  $error("reg_address exp %0h got %0h", exp_w.addr, got.addr);
                  errors++;
               end
               if (got.data != exp_w.data) begin
                  $error("reg_byte exp %0h got %0h", exp_w.data, got.data);
                  errors++;
               end
               if (got.last != exp_w.last) begin
                  $error("last_write exp %0b got %0b", exp_w.last, got.last);
                  errors++;
               end
               if (got.range_err != exp_w.range_err) begin
                  $error("range_error exp %0b got %0b", exp_w.range_err, got.range_err);
                  errors++;
               end
            end
         end
      end
   end

   task automatic add_req(input logic [27:0] t, input logic [7:0] b);
      pending_reqs.push_back('{target: t, base: b});
   endtask

   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_tvalid || expected_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [VCO_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_VCO) vco_hz = val;
      else offset_hz = val[OFS_W-1:0];
   endtask

   // plausible targets half the time, otherwise full-range or small ones
   task automatic add_random(input int n);
      logic [27:0] t;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: t = 28'($urandom());
            1: t = 28'($urandom_range(0, 2000));
            default: t = 28'($urandom_range(100000, 120000000));
         endcase
         add_req(t, ($urandom_range(0, 4) == 0) ? 8'($urandom_range(240, 255))
                                                 : 8'($urandom()));
      end
   endtask

   initial begin
      vco_hz = VCO_RESET;
      offset_hz = OFS_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, field extremes, address wrap, out of range
      add_req(28'd0, 8'd0);
      add_req(28'hFFFFFFF, 8'd248);
      add_req(28'd7100000, 8'd26);
      add_req(28'd14200000, 8'd255);
      add_req(28'd216000000, 8'd249);
      add_req(28'd100, 8'hAA);
      add_req(28'd5555555, 8'h55);
      add_random(40);
      wait_idle();

      // zero sum, a above maximum
      write_csr(CSR_OFFSET, '0);
      write_csr(CSR_VCO, 30'h3FFFFFFF);
      add_req(28'd0, 8'd3);
      add_req(28'd1, 8'd250);
      add_req(28'd31564544, 8'd16);
      wait_idle();
      add_req(28'd1, 8'd0);
      add_req(28'd523776, 8'd8);
      add_req(28'd523775, 8'd8);
      add_random(45);
      wait_idle();

      write_csr(CSR_VCO, '0);
      write_csr(CSR_OFFSET, 26'h3FFFFFF);
      add_req(28'd0, 8'd0);
      add_req(28'hFFFFFFF, 8'hFF);
      add_random(10);
      wait_idle();

      write_csr(CSR_VCO, 30'd750000000);
      write_csr(CSR_OFFSET, 26'($urandom_range(0, 20000000)));
      add_random(45);
      // part way through, stop sending until every expected write has arrived
      while (pending_reqs.size() > 20) @(posedge clock);
      hold_off = 1'b1;
      while (expected_writes.size() != 0 || req_tvalid) @(posedge clock);
      hold_off = 1'b0;
      wait_idle();

      write_csr(CSR_VCO, 30'($urandom_range(400000000, 1073741823)));
      write_csr(CSR_OFFSET, 26'($urandom()));
      add_random(40);
      wait_idle();

      $display("%0d requests sent, %0d write transactions checked, %0d flagged out of range",
               reqs_sent, writes_seen, errs_seen);
      $display("covered reset, extreme and random register settings, address wrap");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
